// ----- rtl/tccs_pkg.sv -----
// Shared types and constants for the text console engine.
// No dependencies; imported by tccs_front, tccs_back and the top level.
package tccs_pkg;

   // Screen geometry. Cells must stay at or below 2048 (11-bit cursor port).
   localparam int Cols     = 80;
   localparam int Rows     = 25;
   localparam int Cells    = Cols * Rows;
   localparam int CellAw   = $clog2(Cells);
   localparam int ColW     = $clog2(Cols);
   localparam int CopyLen  = Cells - Cols;

   // Fixed port widths.
   localparam int CmdW     = 1;
   localparam int CharW    = 8;
   localparam int IndexW   = 11;
   localparam int CursorW  = 11;

   localparam logic [CmdW-1:0]  CmdPut      = 1'b0;
   localparam logic [CmdW-1:0]  CmdRead     = 1'b1;
   localparam logic [CharW-1:0] ChNewline   = 8'd10;
   localparam logic [CharW-1:0] ChBackspace = 8'd8;

   // Command queue between front and back.
   localparam int OpQDepth = 2;
   localparam int OpQPw    = $clog2(OpQDepth);
   localparam int OpQCw    = $clog2(OpQDepth + 1);

   typedef enum logic [1:0] {
      OP_READ,
      OP_NEWLINE,
      OP_BACKSPACE,
      OP_CHAR
   } op_kind_type;

   typedef struct packed {
      op_kind_type          kind;
      logic [CharW-1:0]     char_code;
      logic [IndexW-1:0]    cell_index;
   } op_type;

endpackage

// ----- rtl/tccs_front.sv -----
// Front end: accepts request beats, classifies them, and queues them for the back end.
// Depends on tccs_pkg.
module tccs_front import tccs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [CmdW-1:0]   req_cmd,
   input  logic [CharW-1:0]  req_char_code,
   input  logic [IndexW-1:0] req_cell_index,
   input  logic              busy,
   output logic              op_valid,
   output op_type            op,
   input  logic              op_take
);

   op_type             q_ff [OpQDepth];
   logic [OpQPw-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [OpQPw-1:0]   wr_ptr_in, rd_ptr_in;
   logic [OpQCw-1:0]   cnt_ff, cnt_in;
   logic               push_ok;
   logic               pop_ok;
   op_type             new_op;

   assign req_full = busy || (cnt_ff == OpQCw'(OpQDepth));
   assign push_ok  = req_push && !req_full;
   assign op_valid = (cnt_ff != '0);
   assign pop_ok   = op_take && op_valid;
   assign op       = q_ff[rd_ptr_ff];

   always_comb begin
      new_op.char_code  = req_char_code;
      new_op.cell_index = req_cell_index;
      priority if (req_cmd == CmdRead) begin
         new_op.kind = OP_READ;
      end else if (req_char_code == ChNewline) begin
         new_op.kind = OP_NEWLINE;
      end else if (req_char_code == ChBackspace) begin
         new_op.kind = OP_BACKSPACE;
      end else begin
         new_op.kind = OP_CHAR;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == OpQPw'(OpQDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == OpQPw'(OpQDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push_ok, pop_ok})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= new_op;
      end
   end

endmodule

// ----- rtl/tccs_back.sv -----
// Back end: screen memory, cursor, scroll sequencer and the result register.
// Depends on tccs_pkg.
module tccs_back import tccs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               op_valid,
   input  op_type             op,
   output logic               op_take,
   output logic               busy,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [CursorW-1:0] rsp_cursor_pos,
   output logic [CharW-1:0]   rsp_cell_data,
   output logic               rsp_scrolled
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_COPY
   } state_type;

   state_type           state_ff;
   logic                init_ff;
   logic [CellAw-1:0]   cursor_ff;
   logic [ColW-1:0]     col_ff;
   logic [CellAw-1:0]   cnt_ff;
   logic                out_valid_ff;
   logic [CharW-1:0]    res_data_ff;
   logic                res_scrolled_ff;

   logic [CharW-1:0]    mem [Cells];
   logic [CharW-1:0]    rd_data_ff;
   logic                rd_en;
   logic [CellAw-1:0]   rd_addr;
   logic                mem_we;
   logic [CellAw-1:0]   mem_waddr;
   logic [CharW-1:0]    mem_wdata;

   logic [CellAw:0]     adv_pos;
   logic [CellAw:0]     nl_pos;
   logic [ColW-1:0]     col_inc;
   logic [ColW-1:0]     col_dec;
   logic                idx_in_range;

   assign op_take   = (state_ff == ST_IDLE) && op_valid && !out_valid_ff;
   assign busy      = init_ff;
   assign rsp_empty = !out_valid_ff;
   assign rsp_cursor_pos = CursorW'(cursor_ff);
   assign rsp_cell_data  = res_data_ff;
   assign rsp_scrolled   = res_scrolled_ff;

   assign adv_pos      = {1'b0, cursor_ff} + 1'b1;
   assign nl_pos       = {1'b0, cursor_ff} - (CellAw + 1)'(col_ff) + (CellAw + 1)'(Cols);
   assign col_inc      = (col_ff == ColW'(Cols - 1)) ? '0 : col_ff + 1'b1;
   assign col_dec      = (col_ff == '0) ? ColW'(Cols - 1) : col_ff - 1'b1;
   assign idx_in_range = (32'(op.cell_index) < Cells);

   // Memory port control. During a copy the read runs one row ahead of the write.
   always_comb begin
      rd_en     = 1'b0;
      rd_addr   = CellAw'(op.cell_index);
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_COPY: begin
            rd_en   = (32'(cnt_ff) < CopyLen);
            rd_addr = CellAw'(32'(cnt_ff) + Cols);
            if (cnt_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = cnt_ff - 1'b1;
               mem_wdata = rd_data_ff;
            end
         end
         ST_IDLE: begin
            if (op_take) begin
               unique case (op.kind)
                  OP_READ: begin
                     rd_en = idx_in_range;
                  end
                  OP_CHAR: begin
                     mem_we    = 1'b1;
                     mem_waddr = cursor_ff;
                     mem_wdata = op.char_code;
                  end
                  OP_BACKSPACE: begin
                     mem_we    = (cursor_ff != '0);
                     mem_waddr = cursor_ff - 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         init_ff         <= 1'b1;
         cursor_ff       <= '0;
         col_ff          <= '0;
         cnt_ff          <= '0;
         out_valid_ff    <= 1'b0;
         res_data_ff     <= '0;
         res_scrolled_ff <= 1'b0;
      end else begin
         if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (32'(cnt_ff) == Cells - 1) begin
                  state_ff <= ST_IDLE;
                  init_ff  <= 1'b0;
                  if (!init_ff) begin
                     out_valid_ff <= 1'b1;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_COPY: begin
               if (32'(cnt_ff) == CopyLen) begin
                  // bottom row is cleared by the same sweep used after reset
                  state_ff <= ST_CLEAR;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_READ: begin
               res_data_ff  <= rd_data_ff;
               out_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_IDLE: begin
               if (op_take) begin
                  res_data_ff     <= '0;
                  res_scrolled_ff <= 1'b0;
                  unique case (op.kind)
                     OP_READ: begin
                        if (idx_in_range) begin
                           state_ff <= ST_READ;
                        end else begin
                           out_valid_ff <= 1'b1;
                        end
                     end
                     OP_NEWLINE: begin
                        col_ff <= '0;
                        if (32'(nl_pos) >= Cells) begin
                           cursor_ff       <= CellAw'(nl_pos - (CellAw + 1)'(Cols));
                           res_scrolled_ff <= 1'b1;
                           cnt_ff          <= '0;
                           state_ff        <= ST_COPY;
                        end else begin
                           cursor_ff    <= CellAw'(nl_pos);
                           out_valid_ff <= 1'b1;
                        end
                     end
                     OP_BACKSPACE: begin
                        if (cursor_ff != '0) begin
                           cursor_ff <= cursor_ff - 1'b1;
                           col_ff    <= col_dec;
                        end
                        out_valid_ff <= 1'b1;
                     end
                     OP_CHAR: begin
                        col_ff <= col_inc;
                        if (32'(adv_pos) >= Cells) begin
                           cursor_ff       <= CellAw'(adv_pos - (CellAw + 1)'(Cols));
                           res_scrolled_ff <= 1'b1;
                           cnt_ff          <= '0;
                           state_ff        <= ST_COPY;
                        end else begin
                           cursor_ff    <= CellAw'(adv_pos);
                           out_valid_ff <= 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      32'(cursor_ff) < Cells)
      else $error("cursor outside the screen");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < Cols)
      else $error("column counter outside the row");

   a_take_no_pending: assert property (@(posedge clock) disable iff (reset)
      op_take |-> !out_valid_ff && !init_ff)
      else $error("command taken while a result is pending or clear runs");

   a_scroll_bottom_row: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && res_scrolled_ff) |-> (32'(cursor_ff) >= CopyLen))
      else $error("scroll left cursor above the bottom row");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> out_valid_ff && $stable(cursor_ff)
         && $stable(res_data_ff) && $stable(res_scrolled_ff))
      else $error("pending result changed before pop");
`endif

endmodule

// ----- rtl/text_console_cursor_scroll.sv -----
// Text console engine: a Rows x Cols character screen with a linear cursor.
// Reads pass through the back end's READ state; ordinary puts, newlines and
// backspaces are done as they are taken. A put or newline that scrolls is taken,
// then moves the rows up through the single-write screen memory in the COPY
// state and clears the bottom row in the CLEAR state. After reset the screen
// memory is swept to zero while req_full stays high.
// A two-entry command queue lets requests be taken while the back end works.
// Depends on tccs_pkg, tccs_front and tccs_back.
module text_console_cursor_scroll import tccs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [CmdW-1:0]    req_cmd,
   input  logic [CharW-1:0]   req_char_code,
   input  logic [IndexW-1:0]  req_cell_index,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [CursorW-1:0] rsp_cursor_pos,
   output logic [CharW-1:0]   rsp_cell_data,
   output logic               rsp_scrolled
);

   logic    op_valid;
   op_type  op;
   logic    op_take;
   logic    busy;

   tccs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .busy           (busy),
      .op_valid       (op_valid),
      .op             (op),
      .op_take        (op_take)
   );

   tccs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .op_valid       (op_valid),
      .op             (op),
      .op_take        (op_take),
      .busy           (busy),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_data  (rsp_cell_data),
      .rsp_scrolled   (rsp_scrolled)
   );

endmodule

// ----- tb/text_console_cursor_scroll_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for text_console_cursor_scroll: puts, newlines, backspaces,
// scrolling and cell reads, checked beat by beat against a screen model kept here.
// Depends on tccs_pkg and the text_console_cursor_scroll RTL.
module text_console_cursor_scroll_test;
   import tccs_pkg::*;

   localparam int CycleLimit = 3_000_000;
   localparam int RandomOps  = 240;
   localparam int QuietTail  = 40;

   typedef struct packed {
      logic [CursorW-1:0] cursor_pos;
      logic [CharW-1:0]   cell_data;
      logic               scrolled;
   } console_report_type;

   logic               clock;
   logic               reset          = 1'b1;
   logic               req_push       = 1'b0;
   logic               req_full;
   logic [CmdW-1:0]    req_cmd        = CmdPut;
   logic [CharW-1:0]   req_char_code  = '0;
   logic [IndexW-1:0]  req_cell_index = '0;
   logic               rsp_empty;
   logic               rsp_pop        = 1'b0;
   logic [CursorW-1:0] rsp_cursor_pos;
   logic [CharW-1:0]   rsp_cell_data;
   logic               rsp_scrolled;

   // screen model
   logic [CharW-1:0]   screen_model [Cells];
   int                 cursor_model;
   console_report_type pending_reports [$];

   bit                 idle_on = 1'b1;
   int                 rsp_hold_cycles = 0;
   int                 fail_count = 0;
   longint             cycle_count = 0;

   text_console_cursor_scroll dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_data  (rsp_cell_data),
      .rsp_scrolled   (rsp_scrolled)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Moves the cursor; past the last row everything shifts up a row.
   function automatic bit move_cursor(int pos);
      cursor_model = pos;
      if (cursor_model / Cols >= Rows) begin
         for (int i = 0; i < CopyLen; i++)
            screen_model[i] = screen_model[i + Cols];
         for (int i = CopyLen; i < Cells; i++)
            screen_model[i] = '0;
         cursor_model -= Cols;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void predict_console_step(input logic [CmdW-1:0] cmd,
                                                input logic [CharW-1:0] ch,
                                                input logic [IndexW-1:0] idx);
      console_report_type rep;
      rep = '0;
      if (cmd == CmdRead) begin
         if (int'(idx) < Cells)
            rep.cell_data = screen_model[idx];
      end else if (ch == ChNewline) begin
         rep.scrolled = move_cursor((cursor_model / Cols + 1) * Cols);
      end else if (ch == ChBackspace) begin
         if (cursor_model > 0) begin
            cursor_model--;
            screen_model[cursor_model] = '0;
         end
      end else begin
         screen_model[cursor_model] = ch;
         rep.scrolled = move_cursor(cursor_model + 1);
      end
      rep.cursor_pos = cursor_model[CursorW-1:0];
      pending_reports.push_back(rep);
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : result_check
      console_report_type want;
      if (!reset && rsp_pop === 1'b1 && rsp_empty === 1'b0) begin
         if (pending_reports.size() == 0) begin
            fail_count++;
            $display("%0t: result beat expected none got cursor_pos %0d", $time,
                     rsp_cursor_pos);
         end else begin
            want = pending_reports.pop_front();
            check_field("cursor_pos", int'(want.cursor_pos), int'(rsp_cursor_pos));
            check_field("cell_data", int'(want.cell_data), int'(rsp_cell_data));
            check_field("scrolled", int'(want.scrolled), int'(rsp_scrolled));
         end
      end
   end

   // Result side: random stall bursts, plus a long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            rsp_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_pop <= 1'b0;
            stall_left = $urandom_range(0, 9);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic send_console_op(input logic [CmdW-1:0] cmd,
                                  input logic [CharW-1:0] ch,
                                  input logic [IndexW-1:0] idx);
      int gap;
      gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push       <= 1'b1;
      req_cmd        <= cmd;
      req_char_code  <= ch;
      req_cell_index <= idx;
      do @(posedge clock); while (req_full !== 1'b0);
      predict_console_step(cmd, ch, idx);
   endtask

   task automatic drain_console;
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [IndexW-1:0] pick_read_cell;
      int sel;
      int lo;
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
         lo = (cursor_model > 160) ? cursor_model - 160 : 0;
         return IndexW'($urandom_range(cursor_model, lo));
      end else if (sel < 9) begin
         return IndexW'($urandom_range(0, Cells - 1));
      end
      return IndexW'($urandom_range(Cells, (1 << IndexW) - 1));
   endfunction

   // Field extremes, zero byte, backspace at home, out-of-range reads.
   task automatic test_directed_edges;
      send_console_op(CmdRead, 8'h00, '0);
      send_console_op(CmdRead, 8'hFF, IndexW'(Cells - 1));
      send_console_op(CmdRead, ChNewline, IndexW'(Cells));
      send_console_op(CmdRead, ChBackspace, '1);
      send_console_op(CmdPut, ChBackspace, '0);
      send_console_op(CmdPut, 8'h00, '1);
      send_console_op(CmdPut, 8'hFF, '0);
      send_console_op(CmdPut, 8'h41, '1);
      send_console_op(CmdPut, ChBackspace, '0);
      send_console_op(CmdRead, 8'h00, 11'd2);
      send_console_op(CmdRead, 8'h00, 11'd0);
      send_console_op(CmdRead, 8'h00, 11'd1);
      send_console_op(CmdPut, 8'h5A, '0);
   endtask

   // Walk to the bottom row, then a newline there scrolls row 1 into row 0.
   task automatic test_newline_scroll;
      send_console_op(CmdPut, ChNewline, '0);
      send_console_op(CmdPut, 8'h42, '0);
      send_console_op(CmdRead, 8'h00, IndexW'(Cols));
      repeat (Rows - 2)
         send_console_op(CmdPut, ChNewline, IndexW'($urandom_range(0, 2047)));
      send_console_op(CmdPut, ChNewline, '0);
      send_console_op(CmdRead, 8'h00, 11'd0);
      send_console_op(CmdRead, 8'h00, IndexW'(Cells - 1));
   endtask

   // Result side holds off while requests keep coming, so the input stalls.
   task automatic test_receiver_holdoff;
      idle_on = 1'b0;
      rsp_hold_cycles = 300;
      repeat (16)
         send_console_op(CmdRead, CharW'($urandom_range(0, 255)), pick_read_cell());
      idle_on = 1'b1;
   endtask

   task automatic test_sender_pause;
      drain_console();
      repeat (6)
         send_console_op(CmdRead, CharW'($urandom_range(0, 255)), pick_read_cell());
      send_console_op(CmdPut, CharW'($urandom_range(32, 126)),
                      IndexW'($urandom_range(0, 2047)));
   endtask

   task automatic test_random_traffic;
      int pick;
      logic [CharW-1:0] ch;
      logic [IndexW-1:0] idx;
      for (int n = 0; n < RandomOps; n++) begin
         idle_on = (n < RandomOps - QuietTail);
         pick = $urandom_range(0, 99);
         ch   = CharW'($urandom_range(0, 255));
         idx  = IndexW'($urandom_range(0, 2047));
         if (pick < 8)
            send_console_op(CmdPut, ChNewline, idx);
         else if (pick < 16)
            send_console_op(CmdPut, ChBackspace, idx);
         else if (pick < 60)
            send_console_op(CmdPut, ch, idx);
         else
            send_console_op(CmdRead, ch, pick_read_cell());
      end
   endtask

   initial begin
      foreach (screen_model[i])
         screen_model[i] = '0;
      cursor_model = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_newline_scroll();
      test_receiver_holdoff();
      test_sender_pause();
      test_random_traffic();

      drain_console();
      // every beat has a result, so a short quiet spell catches strays
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/tccs_pkg.sv
rtl/tccs_front.sv
rtl/tccs_back.sv
rtl/text_console_cursor_scroll.sv
tb/text_console_cursor_scroll_test.sv
